[rtl/mcpg_pkg.sv]
// ----------------------------------------------------------------------------
// mcpg_pkg - shared types and constants
// Operation and register codes, reset values, and the step record passed
// from the front end through the queue to the pixel emitter.
// ----------------------------------------------------------------------------
package mcpg_pkg;

   localparam int COORD_W     = 16;
   localparam int QUEUE_DEPTH = 2;

   // request operation codes
   localparam logic OP_START = 1'b0;

   // register indexes
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ROW_PITCH     = 2'd2;
   localparam logic [1:0] CSR_FRAME_BASE    = 2'd3;

   localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
   localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;
   localparam logic [15:0] RST_ROW_PITCH     = 16'd2560;
   localparam logic [31:0] RST_FRAME_BASE    = 32'd0;

   // octant index of the eighth pixel of a step
   localparam logic [2:0] OCT_LAST = 3'd7;

   typedef struct packed {
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic [15:0] row_pitch;
      logic [31:0] frame_base;
   } cfg_type;

   // one iteration: offsets are the values before the update
   typedef struct packed {
      logic signed [COORD_W-1:0] center_col;
      logic signed [COORD_W-1:0] center_row;
      logic [COORD_W-1:0]        outer_ofs;
      logic [COORD_W-1:0]        inner_ofs;
      logic [31:0]               color;
      logic                      real_step;
      logic                      done;
   } step_type;

endpackage

[rtl/mcpg_front.sv]
// ----------------------------------------------------------------------------
// mcpg_front - request intake and circle iteration
// Holds the circle state, runs one midpoint iteration per accepted
// transaction and pushes the resulting step record into the queue.
// ----------------------------------------------------------------------------
module mcpg_front #(
   parameter int RADIUS_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_operation,
   input  logic signed [14:0]       req_center_x,
   input  logic signed [14:0]       req_center_y,
   input  logic [11:0]              req_radius,
   input  logic [31:0]              req_color,
   input  logic                     full_i,
   output logic                     push_o,
   output mcpg_pkg::step_type       step_o
);

   localparam int OFS_W     = RADIUS_BITS + 1;
   localparam int ERR_W     = OFS_W + 3;
   localparam int MASK_BITS = (RADIUS_BITS < 12) ? RADIUS_BITS : 12;
   localparam logic [11:0] RAD_MASK = 12'((13'd1 << MASK_BITS) - 13'd1);

   logic [OFS_W-1:0]                 a_ff, a_in;
   logic [OFS_W-1:0]                 b_ff, b_in;
   logic signed [ERR_W-1:0]          e_ff, e_in;
   logic signed [mcpg_pkg::COORD_W-1:0] cx_ff, cx_in;
   logic signed [mcpg_pkg::COORD_W-1:0] cy_ff, cy_in;
   logic [31:0]                      color_ff, color_in;

   logic                    start;
   logic [OFS_W-1:0]        rad_ld;
   logic [OFS_W-1:0]        cur_a, cur_b, a_nx, b_nx;
   logic signed [ERR_W-1:0] cur_e, e1, e_nx;
   logic                    real_step;

   assign start  = (req_operation == mcpg_pkg::OP_START);
   assign push_o = req_valid && !full_i;
   assign rad_ld = OFS_W'(req_radius & RAD_MASK);

   always_comb begin
      cur_a = start ? rad_ld : a_ff;
      cur_b = start ? '0 : b_ff;
      cur_e = start ? -$signed(ERR_W'(rad_ld)) : e_ff;
      real_step = cur_a > cur_b;
      e1   = cur_e + $signed(ERR_W'({cur_b, 1'b0}) + ERR_W'(2));
      b_nx = cur_b + 1'b1;
      a_nx = cur_a;
      e_nx = e1;
      if (!e1[ERR_W-1]) begin
         a_nx = cur_a - 1'b1;
         e_nx = e1 - $signed(ERR_W'({a_nx, 1'b0})) + $signed(ERR_W'(1));
      end
      a_in     = real_step ? a_nx : cur_a;
      b_in     = real_step ? b_nx : cur_b;
      e_in     = real_step ? e_nx : cur_e;
      cx_in    = start ? mcpg_pkg::COORD_W'(req_center_x) : cx_ff;
      cy_in    = start ? mcpg_pkg::COORD_W'(req_center_y) : cy_ff;
      color_in = start ? req_color : color_ff;
   end

   always_comb begin
      step_o.center_col = cx_in;
      step_o.center_row = cy_in;
      step_o.outer_ofs  = mcpg_pkg::COORD_W'(cur_a);
      step_o.inner_ofs  = mcpg_pkg::COORD_W'(cur_b);
      step_o.color      = color_in;
      step_o.real_step  = real_step;
      step_o.done       = !(a_in > b_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff     <= '0;
         b_ff     <= '0;
         e_ff     <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         color_ff <= '0;
      end else if (push_o) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         e_ff     <= e_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         color_ff <= color_in;
      end
   end

   // a real iteration always advances the inner offset by one
   a_inner_step: assert property (@(posedge clock) disable iff (reset)
      (push_o && real_step) |=> (b_ff == $past(b_nx)))
      else $error("inner offset did not advance");

   // the outer offset never drops below the inner offset minus one
   a_offsets_order: assert property (@(posedge clock) disable iff (reset)
      (push_o && real_step) |=> ({1'b0, a_ff} + 1'b1 >= {1'b0, b_ff}))
      else $error("offsets crossed");

endmodule

[rtl/mcpg_queue.sv]
// ----------------------------------------------------------------------------
// mcpg_queue - step record queue
// Short FIFO that decouples the iteration front end from the pixel emitter.
// ----------------------------------------------------------------------------
module mcpg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_i,
   input  mcpg_pkg::step_type step_i,
   input  logic               pop_i,
   output mcpg_pkg::step_type step_o,
   output logic               full_o,
   output logic               empty_o
);

   localparam int DEPTH = mcpg_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mcpg_pkg::step_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full_o  = (count_ff == CNT_W'(DEPTH));
   assign empty_o = (count_ff == '0);
   assign step_o  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= step_i;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_i && full_o))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop_i && empty_o))
      else $error("pop from empty queue");

endmodule

[rtl/mcpg_back.sv]
// ----------------------------------------------------------------------------
// mcpg_back - octant pixel emitter
// Walks each step's eight octant pixels, one per cycle unless stalled, and
// computes clipping and the framebuffer byte address into the output stage.
// ----------------------------------------------------------------------------
module mcpg_back (
   input  logic               clock,
   input  logic               reset,
   input  mcpg_pkg::cfg_type  cfg_i,
   input  mcpg_pkg::step_type step_i,
   input  logic               empty_i,
   output logic               pop_o,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pixel_x,
   output logic signed [15:0] rsp_pixel_y,
   output logic [31:0]        rsp_byte_address,
   output logic [31:0]        rsp_pixel_value,
   output logic               rsp_write_enable,
   output logic               rsp_last_of_step,
   output logic               rsp_circle_done
);

   mcpg_pkg::step_type step_ff;
   logic               step_valid_ff, step_valid_in;
   logic [2:0]         oct_ff, oct_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [15:0] x_ff, y_ff;
   logic [31:0]        addr_ff, value_ff;
   logic               we_ff, last_ff, done_ff;

   logic               adv, oct_end;
   logic signed [15:0] cx, cy, px, py;
   logic [15:0]        a, b;
   logic signed [15:0] xa1, xan, xb0, xbn, ya1, yan, yb0, ybn;
   logic signed [32:0] row_prod;
   logic [31:0]        col_ofs, addr;
   logic               we;

   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign oct_end = (oct_ff == mcpg_pkg::OCT_LAST);
   assign pop_o   = !empty_i && (!step_valid_ff || (adv && oct_end));

   always_comb begin
      cx  = step_ff.center_col;
      cy  = step_ff.center_row;
      a   = step_ff.outer_ofs;
      b   = step_ff.inner_ofs;
      xa1 = cx + a - 16'sd1;
      xan = cx - a;
      xb0 = cx + b;
      xbn = cx + ~b;
      ya1 = cy + a - 16'sd1;
      yan = cy - a;
      yb0 = cy + b;
      ybn = cy + ~b;
      // even octants step x on the outer offset, odd ones on the inner
      if (!oct_ff[0]) begin
         px = oct_ff[1] ? xan : xa1;
         py = oct_ff[2] ? ybn : yb0;
      end else begin
         px = oct_ff[2] ? xbn : xb0;
         py = oct_ff[1] ? yan : ya1;
      end
   end

   assign row_prod = py * $signed({1'b0, cfg_i.row_pitch});
   assign col_ofs  = {{14{px[15]}}, px, 2'b00};
   assign addr     = cfg_i.frame_base + row_prod[31:0] + col_ofs;
   assign we       = step_ff.real_step && !px[15] && !py[15] &&
                     (px[14:0] < 15'(cfg_i.screen_width)) &&
                     (py[14:0] < 15'(cfg_i.screen_height));

   always_comb begin
      step_valid_in = step_valid_ff;
      oct_in        = oct_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = step_valid_ff;
         if (step_valid_ff) begin
            oct_in = oct_ff + 1'b1;
            if (oct_end) begin
               step_valid_in = 1'b0;
            end
         end
      end
      if (pop_o) begin
         step_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_valid_ff <= 1'b0;
         oct_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_valid_ff <= step_valid_in;
         oct_ff        <= oct_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_o) begin
         step_ff <= step_i;
      end
      if (adv && step_valid_ff) begin
         x_ff     <= px;
         y_ff     <= py;
         addr_ff  <= addr;
         value_ff <= step_ff.color;
         we_ff    <= we;
         last_ff  <= oct_end;
         done_ff  <= step_ff.done;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = x_ff;
   assign rsp_pixel_y      = y_ff;
   assign rsp_byte_address = addr_ff;
   assign rsp_pixel_value  = value_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_circle_done  = done_ff;

   a_we_on_screen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_write_enable) |-> (!rsp_pixel_x[15] && !rsp_pixel_y[15]))
      else $error("write enable on negative coordinate");

   // mid-step octant index only exists while a step is held
   a_oct_held: assert property (@(posedge clock) disable iff (reset)
      (oct_ff != 3'd0) |-> step_valid_ff)
      else $error("octant counter running without step");

endmodule

[rtl/midpoint_circle_pixel_generator.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_pixel_generator - midpoint circle rasterizer
// Path: queue entry, emitter step register, then the registered rsp outputs.
// Throughput: one pixel per cycle on the rsp channel while rsp_stall is low;
// the pixel emitter is the bottleneck, the front end iterates combinationally.
// A two-entry step queue lets req accept ahead while pixels drain.
// Reset: registers return to 640x480, pitch 2560, base 0; circle state clears.
// ----------------------------------------------------------------------------
module midpoint_circle_pixel_generator #(
   parameter int RADIUS_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic signed [14:0] req_center_x,
   input  logic signed [14:0] req_center_y,
   input  logic [11:0]        req_radius,
   input  logic [31:0]        req_color,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pixel_x,
   output logic signed [15:0] rsp_pixel_y,
   output logic [31:0]        rsp_byte_address,
   output logic [31:0]        rsp_pixel_value,
   output logic               rsp_write_enable,
   output logic               rsp_last_of_step,
   output logic               rsp_circle_done,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   mcpg_pkg::cfg_type  cfg_ff, cfg_in;
   mcpg_pkg::step_type push_step, head_step;
   logic               push, pop, full, empty;

   assign csr_ready = 1'b1;
   assign req_stall = full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mcpg_pkg::CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_data[12:0];
            mcpg_pkg::CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_data[12:0];
            mcpg_pkg::CSR_ROW_PITCH:     cfg_in.row_pitch     = csr_data[15:0];
            mcpg_pkg::CSR_FRAME_BASE:    cfg_in.frame_base    = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= mcpg_pkg::RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= mcpg_pkg::RST_SCREEN_HEIGHT;
         cfg_ff.row_pitch     <= mcpg_pkg::RST_ROW_PITCH;
         cfg_ff.frame_base    <= mcpg_pkg::RST_FRAME_BASE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcpg_front #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_radius    (req_radius),
      .req_color     (req_color),
      .full_i        (full),
      .push_o        (push),
      .step_o        (push_step)
   );

   mcpg_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .step_i  (push_step),
      .pop_i   (pop),
      .step_o  (head_step),
      .full_o  (full),
      .empty_o (empty)
   );

   mcpg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg_i            (cfg_ff),
      .step_i           (head_step),
      .empty_i          (empty),
      .pop_o            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_byte_address (rsp_byte_address),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_write_enable (rsp_write_enable),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_circle_done  (rsp_circle_done)
   );

endmodule
